@@ rtl/csme_pkg.sv @@
// ----------------------------------------------------------------------------
// csme_pkg: shared types and constants for the controller-to-MIDI converter
// Report and message structs, the job format passed from front to back,
// MIDI codes and the layout of the per-report change vector.
// ----------------------------------------------------------------------------
package csme_pkg;

    // Number of touch strip segments compared (top mask bits)
    localparam int StripSegments = 32;

    // Depth of the job queue between front and back
    localparam int QueueDepth = 2;

    // Change vector layout: one position per possible message, in send order
    localparam int PosPedal = 4;
    localparam int PosShift = 6;
    localparam int PosSeg0  = 7;
    localparam int PosBend  = 39;
    localparam int ChgBits  = 40;
    localparam int PosW     = 6;

    // MIDI status nibbles
    localparam logic [3:0] StatusNoteOff = 4'h8;
    localparam logic [3:0] StatusNoteOn  = 4'h9;
    localparam logic [3:0] StatusControl = 4'hB;
    localparam logic [3:0] StatusBend    = 4'hE;

    // MIDI data values
    localparam logic [6:0] CtrlDamper      = 7'd64;
    localparam logic [6:0] CtrlPortamento  = 7'd65;
    localparam logic [6:0] CtrlAllNotesOff = 7'd123;
    localparam logic [6:0] DataMax         = 7'd127;
    localparam logic [6:0] DataZero        = 7'd0;

    // Configuration register indexes
    localparam logic RegPercussionChannel = 1'b0;
    localparam logic RegStripChannel      = 1'b1;

    typedef struct packed {
        logic        kick_pad;
        logic        snare_pad;
        logic        hihat_closed_pad;
        logic        hihat_open_pad;
        logic        damper_pedal;
        logic        portamento_pedal;
        logic [6:0]  note_shift;
        logic [31:0] touch_mask;
        logic [6:0]  bend_value;
    } report_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       last_message;
    } message_t;

    // One job: which messages to send and the new values they carry.
    // now_bits holds pad/pedal bits at positions 0..5 and segment bits
    // (segment i at PosSeg0+i); shift and bend positions are unused there.
    typedef struct packed {
        logic [ChgBits-1:0] chg;
        logic [ChgBits-1:0] now_bits;
        logic [6:0]         shift;
        logic [6:0]         bend;
    } job_t;

    typedef struct packed {
        logic [3:0] percussion;
        logic [3:0] strip;
    } chan_cfg_t;

    function automatic logic [6:0] drum_note(input logic [1:0] pad);
        logic [6:0] n;
        unique case (pad)
            2'd0: n = 7'd35;
            2'd1: n = 7'd38;
            2'd2: n = 7'd42;
            default: n = 7'd46;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/controller_state_to_midi_events_unit.sv @@
// ----------------------------------------------------------------------------
// controller_state_to_midi_events_unit: controller report to MIDI messages
// Input channel (in_valid/in_stall/in_data) takes one controller report per
// item. Output channel (out_valid/out_stall/out_data) gives one three-byte
// MIDI message per item, last_message set on the final message of a report.
// Both channels move an item at an edge with valid high and stall low.
// The front compares a report with the previous one in the cycle it is
// taken and queues a job (two deep); reports with no change give nothing.
// The back fetches a job from the queue, then walks the 40 message positions
// one per cycle, holding at a set bit while the output stalls, and stops
// after the last change; a message passes from the queue through the
// sequencer's job registers into the output register.
// A new job is fetched only after the scan of the previous one ends, so a
// changed report keeps the back busy until its last message is loaded.
// in_stall rises only while the job queue is full.
// When the receiver stalls, the output register holds its message and the
// scan waits on the position it reached; intake continues until the queue
// fills. Reset clears the remembered report, the queue and the output,
// and sets the percussion channel to 9 and the strip channel to 0.
// Channel registers sit on an APB-style port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module controller_state_to_midi_events_unit
#(
    parameter int QueueDepth = csme_pkg::QueueDepth
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  csme_pkg::report_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output csme_pkg::message_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Channel registers
    logic [3:0] perc_chan_reg;
    logic [3:0] strip_chan_reg;
    logic       cfg_write;
    csme_pkg::chan_cfg_t chan_cfg;

    // Front-to-queue and queue-to-back signals
    logic           push;
    csme_pkg::job_t push_job;
    logic           pop;
    csme_pkg::job_t head_job;
    logic           queue_empty;
    logic           queue_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Decode on the word address; byte offset bits are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perc_chan_reg  <= 4'd9;
            strip_chan_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                csme_pkg::RegPercussionChannel: perc_chan_reg  <= pwdata[3:0];
                csme_pkg::RegStripChannel:      strip_chan_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            csme_pkg::RegPercussionChannel: prdata = {28'd0, perc_chan_reg};
            csme_pkg::RegStripChannel:      prdata = {28'd0, strip_chan_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    assign chan_cfg.percussion = perc_chan_reg;
    assign chan_cfg.strip      = strip_chan_reg;

    // Detect changes and queue a job per changed report
    csme_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Hold up to two jobs so intake runs ahead of message output
    csme_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // Sequence the messages of one job into the output register
    csme_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chan_cfg    (chan_cfg),
        .head_job    (head_job),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

@@ rtl/csme_front.sv @@
// ----------------------------------------------------------------------------
// csme_front: report intake and change detection
// Compares each report with the remembered one, builds a job of pending
// messages and pushes it to the queue; reports with no change are dropped.
// ----------------------------------------------------------------------------
module csme_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  csme_pkg::report_t  in_data,
    output logic               in_stall,
    input  logic               queue_full,
    output logic               push,
    output csme_pkg::job_t     push_job
);

    logic [5:0]  prev_sw_reg;
    logic [6:0]  prev_shift_reg;
    logic [31:0] prev_touch_reg;
    logic [6:0]  prev_bend_reg;

    logic        accept;
    logic [5:0]  sw;
    logic        shift_chg;
    logic [31:0] prev_t;
    logic [31:0] seg_now;
    logic [31:0] seg_chg;

    assign accept   = in_valid && !queue_full;
    assign in_stall = queue_full;

    always_comb
    begin
        sw = {in_data.portamento_pedal, in_data.damper_pedal, in_data.hihat_open_pad,
              in_data.hihat_closed_pad, in_data.snare_pad, in_data.kick_pad};
        shift_chg = (in_data.note_shift != prev_shift_reg);
        // a shift change forgets the old touch state
        prev_t = shift_chg ? 32'd0 : prev_touch_reg;
        for (int i = 0; i < 32; i++)
        begin
            seg_now[i] = in_data.touch_mask[31-i];
            seg_chg[i] = (i < csme_pkg::StripSegments)
                         && (in_data.touch_mask[31-i] != prev_t[31-i]);
        end
        push_job.chg      = {(in_data.bend_value != prev_bend_reg), seg_chg, shift_chg,
                             sw ^ prev_sw_reg};
        push_job.now_bits = {1'b0, seg_now, 1'b0, sw};
        push_job.shift    = in_data.note_shift;
        push_job.bend     = in_data.bend_value;
    end

    assign push = accept && (|push_job.chg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sw_reg    <= '0;
            prev_shift_reg <= '0;
            prev_touch_reg <= '0;
            prev_bend_reg  <= '0;
        end
        else if (accept)
        begin
            prev_sw_reg    <= sw;
            prev_shift_reg <= in_data.note_shift;
            prev_touch_reg <= in_data.touch_mask;
            prev_bend_reg  <= in_data.bend_value;
        end
    end

endmodule

@@ rtl/csme_queue.sv @@
// ----------------------------------------------------------------------------
// csme_queue: short job queue between front and back
// Small circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module csme_queue
#(
    parameter int Depth = csme_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csme_pkg::job_t  push_job,
    input  logic            pop,
    output csme_pkg::job_t  head_job,
    output logic            empty,
    output logic            full
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    csme_pkg::job_t mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CntW'(Depth));
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
`endif

endmodule

@@ rtl/csme_back.sv @@
// ----------------------------------------------------------------------------
// csme_back: message sequencer
// Takes one job from the queue and walks its change vector one position per
// cycle, loading a MIDI message into the free output register at each set bit.
// ----------------------------------------------------------------------------
module csme_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  csme_pkg::chan_cfg_t chan_cfg,
    input  csme_pkg::job_t      head_job,
    input  logic                queue_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output csme_pkg::message_t  out_data
);

    logic                             busy_reg;
    logic [csme_pkg::PosW-1:0]        pos_reg;
    logic [csme_pkg::ChgBits-1:0]     mask_reg;
    logic [csme_pkg::ChgBits-1:0]     now_reg;
    logic [6:0]                       shift_reg;
    logic [6:0]                       bend_reg;
    logic                             out_valid_reg;
    csme_pkg::message_t               out_reg;

    logic                             cur_bit;
    logic [csme_pkg::ChgBits-1:0]     rest;
    logic                             slot_free;
    logic                             load;
    logic                             now;
    logic [6:0]                       vel;
    logic [csme_pkg::PosW-1:0]        seg_off;
    logic [7:0]                       pitch_sum;
    logic [6:0]                       pitch;
    csme_pkg::message_t               msg;

    assign cur_bit   = mask_reg[pos_reg];
    assign rest      = mask_reg & ~(csme_pkg::ChgBits'(1) << pos_reg);
    assign slot_free = !out_valid_reg || !out_stall;
    assign load      = busy_reg && cur_bit && slot_free;
    assign pop       = !busy_reg && !queue_empty;

    // Build the message for the current position
    always_comb
    begin
        now       = now_reg[pos_reg];
        vel       = now ? csme_pkg::DataMax : csme_pkg::DataZero;
        seg_off   = pos_reg - csme_pkg::PosW'(csme_pkg::PosSeg0);
        pitch_sum = {3'b000, seg_off[4:0]} + {1'b0, shift_reg};
        pitch     = (pitch_sum > 8'd127) ? csme_pkg::DataMax : pitch_sum[6:0];
        msg.last_message = (rest == '0);
        if (pos_reg < csme_pkg::PosW'(csme_pkg::PosPedal))
        begin
            msg.status_byte = {(now ? csme_pkg::StatusNoteOn : csme_pkg::StatusNoteOff),
                               chan_cfg.percussion};
            msg.data_first  = csme_pkg::drum_note(pos_reg[1:0]);
            msg.data_second = vel;
        end
        else if (pos_reg < csme_pkg::PosW'(csme_pkg::PosShift))
        begin
            msg.status_byte = {csme_pkg::StatusControl, chan_cfg.strip};
            msg.data_first  = pos_reg[0] ? csme_pkg::CtrlPortamento : csme_pkg::CtrlDamper;
            msg.data_second = vel;
        end
        else if (pos_reg == csme_pkg::PosW'(csme_pkg::PosShift))
        begin
            msg.status_byte = {csme_pkg::StatusControl, chan_cfg.strip};
            msg.data_first  = csme_pkg::CtrlAllNotesOff;
            msg.data_second = csme_pkg::DataZero;
        end
        else if (pos_reg < csme_pkg::PosW'(csme_pkg::PosBend))
        begin
            msg.status_byte = {(now ? csme_pkg::StatusNoteOn : csme_pkg::StatusNoteOff),
                               chan_cfg.strip};
            msg.data_first  = pitch;
            msg.data_second = vel;
        end
        else
        begin
            msg.status_byte = {csme_pkg::StatusBend, chan_cfg.strip};
            msg.data_first  = csme_pkg::DataZero;
            msg.data_second = bend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
                mask_reg <= head_job.chg;
            end
            else if (busy_reg)
            begin
                if (!cur_bit)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    mask_reg <= rest;
                    pos_reg  <= pos_reg + 1'b1;
                    if (rest == '0)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            now_reg   <= head_job.now_bits;
            shift_reg <= head_job.shift;
            bend_reg  <= head_job.bend;
        end
        if (load)
        begin
            out_reg <= msg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (mask_reg != '0))
        else $error("sequencer busy with empty change vector");
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= csme_pkg::PosW'(csme_pkg::PosBend)))
        else $error("sequencer position past the last message");
    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (load && msg.last_message) |=> !busy_reg)
        else $error("job continues after its last message");
`endif

endmodule

@@ verif/midi_message_checker.sv @@
// ----------------------------------------------------------------------------
// midi_message_checker: predicts and checks the MIDI message stream
// Watches the report and message channels and the register port of the
// converter, keeps its own copy of the remembered report and the channels,
// and compares every message leaving the block with the oldest prediction.
// ----------------------------------------------------------------------------
module midi_message_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  csme_pkg::report_t   in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  csme_pkg::message_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  failures,
    output int                  pending
);

    localparam logic [3:0] PercussionChanReset = 4'd9;

    logic [3:0]         perc_chan;
    logic [3:0]         strip_chan;
    logic [5:0]         held_switches;
    logic [6:0]         held_shift;
    logic [31:0]        held_touch;
    logic [6:0]         held_bend;
    csme_pkg::message_t expected_msgs[$];
    csme_pkg::message_t want;

    initial failures = 0;

    function automatic logic [6:0] drum_pitch(input int pad);
        logic [6:0] pitch;
        case (pad)
            0: pitch = 7'd35;
            1: pitch = 7'd38;
            2: pitch = 7'd42;
            default: pitch = 7'd46;
        endcase
        return pitch;
    endfunction

    function automatic csme_pkg::message_t midi_msg(input logic [7:0] status,
                                                    input logic [6:0] d1,
                                                    input logic [6:0] d2);
        csme_pkg::message_t m;
        m.status_byte  = status;
        m.data_first   = d1;
        m.data_second  = d2;
        m.last_message = 1'b0;
        return m;
    endfunction

    function automatic csme_pkg::message_t note_msg(input logic [3:0] chan,
                                                    input logic [6:0] pitch,
                                                    input logic on);
        return midi_msg({on ? csme_pkg::StatusNoteOn : csme_pkg::StatusNoteOff, chan}, pitch,
                        on ? csme_pkg::DataMax : csme_pkg::DataZero);
    endfunction

    function automatic void check_field(input string field, input int unsigned expected_val,
                                        input int unsigned actual_val);
        if (expected_val != actual_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, expected_val, actual_val);
            failures++;
        end
    endfunction

    // Queue every message one report causes, in send order, then remember it.
    task automatic predict_report(input csme_pkg::report_t r);
        csme_pkg::message_t batch[$];
        logic [5:0]         now_sw;
        logic [31:0]        prior_touch;
        int                 pitch;
        now_sw = {r.portamento_pedal, r.damper_pedal, r.hihat_open_pad,
                  r.hihat_closed_pad, r.snare_pad, r.kick_pad};
        prior_touch = held_touch;
        for (int i = 0; i < 4; i++)
            if (now_sw[i] != held_switches[i])
                batch.push_back(note_msg(perc_chan, drum_pitch(i), now_sw[i]));
        for (int i = 0; i < 2; i++)
            if (now_sw[i+4] != held_switches[i+4])
                batch.push_back(midi_msg({csme_pkg::StatusControl, strip_chan},
                                         (i == 0) ? csme_pkg::CtrlDamper
                                                  : csme_pkg::CtrlPortamento,
                                         now_sw[i+4] ? csme_pkg::DataMax
                                                     : csme_pkg::DataZero));
        if (r.note_shift != held_shift) begin
            batch.push_back(midi_msg({csme_pkg::StatusControl, strip_chan},
                                     csme_pkg::CtrlAllNotesOff, csme_pkg::DataZero));
            prior_touch = '0;
        end
        for (int i = 0; i < csme_pkg::StripSegments; i++)
            if (r.touch_mask[31-i] != prior_touch[31-i]) begin
                pitch = i + r.note_shift;
                if (pitch > csme_pkg::DataMax)
                    pitch = csme_pkg::DataMax;
                batch.push_back(note_msg(strip_chan, pitch[6:0], r.touch_mask[31-i]));
            end
        if (r.bend_value != held_bend)
            batch.push_back(midi_msg({csme_pkg::StatusBend, strip_chan}, csme_pkg::DataZero,
                                     r.bend_value));
        if (batch.size() > 0)
            batch[batch.size()-1].last_message = 1'b1;
        foreach (batch[k])
            expected_msgs.push_back(batch[k]);
        held_switches = now_sw;
        held_shift    = r.note_shift;
        held_touch    = r.touch_mask;
        held_bend     = r.bend_value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perc_chan     = PercussionChanReset;
            strip_chan    = '0;
            held_switches = '0;
            held_shift    = '0;
            held_touch    = '0;
            held_bend     = '0;
            expected_msgs.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == csme_pkg::RegStripChannel)
                    strip_chan = pwdata[3:0];
                else
                    perc_chan = pwdata[3:0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_msgs.size() == 0)
                begin
                    $error("unexpected message: status_byte 0x%0h data_first %0d data_second %0d",
                           out_data.status_byte, out_data.data_first, out_data.data_second);
                    failures++;
                end
                else
                begin
                    want = expected_msgs.pop_front();
                    check_field("status_byte", want.status_byte, out_data.status_byte);
                    check_field("data_first", want.data_first, out_data.data_first);
                    check_field("data_second", want.data_second, out_data.data_second);
                    check_field("last_message", want.last_message, out_data.last_message);
                end
            end
            if (in_valid && !in_stall)
                predict_report(in_data);
        end
        pending = expected_msgs.size();
    end

endmodule

@@ verif/controller_state_to_midi_events_unit_tb.sv @@
// ----------------------------------------------------------------------------
// controller_state_to_midi_events_unit_tb: stimulus and verdict
// Drives controller reports into the converter under several channel
// settings, with random gaps and stalls on both channels and one long
// receiver hold-off; a checker beside the block predicts every message.
// ----------------------------------------------------------------------------
module controller_state_to_midi_events_unit_tb;

    // Timeout, sized for every report causing 40 messages with each message
    // stalled by the longest burst, plus gaps and the hold-off, then taken several times.
    localparam int CycleLimit    = 2_000_000;
    // Quiet time after the last message: covers the back end's 40-position scan.
    localparam int SettleCycles  = 60;
    // Length of the long receiver hold-off.
    localparam int HoldOffCycles = 400;
    // Top bits of a report hold the six pad and pedal switches.
    localparam int SwitchMsb     = $bits(csme_pkg::report_t) - 1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    csme_pkg::report_t  in_data;
    logic               out_valid;
    logic               out_stall;
    csme_pkg::message_t out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int                mismatch_count;
    int                msgs_pending;
    bit                calm;          // no idling on either side
    bit                sender_gaps;   // sender may insert idle bursts
    bit                hold_off_req;  // receiver runs one long hold-off, then clears it
    csme_pkg::report_t last_sent;

    controller_state_to_midi_events_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    midi_message_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .failures  (mismatch_count),
        .pending   (msgs_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run as failed if it hangs.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[controller_state_to_midi_events_unit] ERROR");
        $finish;
    end

    // Receiver: random stall bursts, calm stretches with no stall, and one long
    // hold-off on request so the block backs up.
    initial
    begin : receiver
        int stretch;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HoldOffCycles) @(negedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                stretch = $urandom_range(1, 13);
                repeat (stretch) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                // hold stall low for a while
                stretch = $urandom_range(20, 80);
                repeat (stretch) @(negedge clk);
            end
        end
    end

    // Build a report from a switch vector ordered kick down to portamento.
    function automatic csme_pkg::report_t make_report(input logic [5:0] switches,
                                                      input logic [6:0] shift,
                                                      input logic [31:0] touch,
                                                      input logic [6:0] bend);
        csme_pkg::report_t r;
        {r.kick_pad, r.snare_pad, r.hihat_closed_pad, r.hihat_open_pad,
         r.damper_pedal, r.portamento_pedal} = switches;
        r.note_shift = shift;
        r.touch_mask = touch;
        r.bend_value = bend;
        return r;
    endfunction

    function automatic csme_pkg::report_t random_report();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(csme_pkg::report_t)-1:0];
    endfunction

    // Next report as a player would send it: mostly a few changes on top of
    // the previous one, now and then a repeat or a completely new report.
    function automatic csme_pkg::report_t vary_report(input csme_pkg::report_t base);
        csme_pkg::report_t r;
        int                pick;
        r = base;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return r;
        if (pick < 4)
            return random_report();
        if ($urandom_range(0, 2) == 0)
            r[SwitchMsb -: 6] = r[SwitchMsb -: 6]
                                ^ 6'($urandom_range(0, 63) & $urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0)
            r.touch_mask ^= $urandom() & $urandom() & $urandom();
        if ($urandom_range(0, 4) == 0)
            r.note_shift = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(96, 127))
                                                        : 7'($urandom_range(0, 127));
        if ($urandom_range(0, 2) == 0)
            r.bend_value = 7'($urandom_range(0, 127));
        return r;
    endfunction

    // Offer one report, hold it until taken, return at the next falling edge.
    task automatic offer_report(input csme_pkg::report_t r);
        int gap;
        if (sender_gaps && !calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        last_sent = r;
        @(negedge clk);
    endtask

    // Setup then access cycle; release psel before returning so back-to-back
    // writes never touch psel twice in one step.
    task automatic write_reg(input logic index, input logic [31:0] value);
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, drain every expected message, then let the scan finish.
    task automatic settle();
        in_valid <= 1'b0;
        wait (msgs_pending == 0);
        repeat (SettleCycles) @(negedge clk);
    endtask

    initial
    begin : stimulus
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        sender_gaps  = 1'b1;
        hold_off_req = 1'b0;
        last_sent    = '0;
        rst_n        = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed reports on the reset channels.
        offer_report(make_report(6'b000000, 7'd0, 32'h0000_0000, 7'd0));    // no change at all
        offer_report(make_report(6'b111111, 7'd0, 32'h0000_0000, 7'd0));    // every pad and pedal on
        offer_report(make_report(6'b101010, 7'd0, 32'h0000_0000, 7'd0));
        offer_report(make_report(6'b010101, 7'd0, 32'h0000_0000, 7'd0));
        offer_report(make_report(6'b000000, 7'd0, 32'h8000_0000, 7'd0));    // segment 0
        offer_report(make_report(6'b000000, 7'd0, 32'h0000_0001, 7'd0));    // last segment
        offer_report(make_report(6'b000000, 7'd0, 32'h0000_0001, 7'd0));    // repeat
        offer_report(make_report(6'b000000, 7'd127, 32'hFFFF_FFFF, 7'd0));  // pitch clamps at 127
        offer_report(make_report(6'b000000, 7'd100, 32'hFFFF_FFFF, 7'd0));  // partly clamped
        offer_report(make_report(6'b000000, 7'd100, 32'hAAAA_5555, 7'd127));
        offer_report(make_report(6'b000000, 7'd100, 32'hAAAA_5555, 7'd0));
        offer_report(make_report(6'b111111, 7'd5, 32'hFFFF_FFFF, 7'd64));   // every message at once
        offer_report(make_report(6'b000000, 7'd5, 32'h0000_0000, 7'd64));
        offer_report(make_report(6'b000000, 7'd0, 32'h0000_0000, 7'd64));   // shift only, strip empty
        offer_report(make_report(6'b000000, 7'd96, 32'h0000_FFFF, 7'd1));
        offer_report(make_report(6'b000000, 7'd96, 32'h7FFF_FFFE, 7'd1));
        offer_report(make_report(6'b000011, 7'd96, 32'h7FFF_FFFE, 7'd1));   // pedals only
        offer_report(make_report(6'b000000, 7'd0, 32'h0000_0000, 7'd0));
        settle();

        // Channel extremes, one way round.
        write_reg(csme_pkg::RegPercussionChannel, 32'h0000_0000);
        write_reg(csme_pkg::RegStripChannel, 32'h0000_000F);
        repeat (100) offer_report(vary_report(last_sent));
        settle();

        // Other way round; the receiver holds off while the sender keeps
        // offering full reports back to back, so the job queue fills.
        write_reg(csme_pkg::RegPercussionChannel, 32'h0000_000F);
        write_reg(csme_pkg::RegStripChannel, 32'h0000_0000);
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        repeat (30) offer_report(random_report());
        sender_gaps = 1'b1;
        repeat (70) offer_report(vary_report(last_sent));
        settle();

        // Random channels with junk in the upper bits of the write data.
        write_reg(csme_pkg::RegPercussionChannel, $urandom());
        write_reg(csme_pkg::RegStripChannel, $urandom());
        repeat (110) offer_report(vary_report(last_sent));
        settle();

        // Final stretch at full rate, no idling anywhere.
        write_reg(csme_pkg::RegStripChannel, $urandom());
        calm = 1'b1;
        repeat (110) offer_report(vary_report(last_sent));
        settle();

        if (mismatch_count == 0)
            $display("[controller_state_to_midi_events_unit] OK");
        else
            $display("[controller_state_to_midi_events_unit] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/csme_pkg.sv
rtl/csme_front.sv
rtl/csme_queue.sv
rtl/csme_back.sv
rtl/controller_state_to_midi_events_unit.sv
verif/midi_message_checker.sv
verif/controller_state_to_midi_events_unit_tb.sv
